/* hw/rtl/bls_pkg.sv */
// ---------------------------------------------------------------------------
// bls_pkg: shared types and constants for the line stepper
// Coordinate width, error term width, action codes and octant fold flags.
// ---------------------------------------------------------------------------
`default_nettype none

package bls_pkg;

   // coordinate width of endpoints and pixels
   localparam int COORD_BITS = 12;
   // signed decision term: 2*minor - 2*major must fit with sign
   localparam int ERR_BITS   = COORD_BITS + 3;

   typedef logic [COORD_BITS-1:0]      coord_type;
   typedef logic signed [ERR_BITS-1:0] err_type;

   // request action codes
   typedef enum logic {
      ACT_START   = 1'b0,
      ACT_ADVANCE = 1'b1
   } action_type;

   // octant fold: swap = major axis is y, xneg / yneg = axis runs negative
   typedef struct packed {
      logic yneg;
      logic xneg;
      logic swap;
   } octant_type;

endpackage : bls_pkg

`default_nettype wire

/* hw/rtl/bresenham_line_stepper_top.sv */
// ---------------------------------------------------------------------------
// bresenham_line_stepper_top: all-octant Bresenham line stepper
// A start beat folds the line into the first octant and returns the first
// endpoint; each advance beat returns the next pixel of the line, or an empty response when no line is active.
// ---------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------
//  req     | in        | req_valid/req_ready  | action, start_x/y, end_x/y
//  rsp     | out       | rsp_valid/rsp_ready  | pixel_x/y, valid_res, last
//
//  One beat per clock while req_ready is high: each accepted request produces
//  its response beat in the output register on the next cycle.
//  The stepping logic (one add, one compare, one add/subtract per axis) sits
//  between the line state and the output register.
//  req_ready drops only while a response is held with rsp_ready low.
//  Synchronous reset clears the active line and the output valid.
//
`default_nettype none

module bresenham_line_stepper_top (
   input  wire                   clock,
   input  wire                   reset,
   // request channel
   input  wire                   req_valid,
   output logic                  req_ready,
   input  wire                   req_action,
   input  wire bls_pkg::coord_type req_start_x,
   input  wire bls_pkg::coord_type req_start_y,
   input  wire bls_pkg::coord_type req_end_x,
   input  wire bls_pkg::coord_type req_end_y,
   // response channel
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output bls_pkg::coord_type    rsp_pixel_x,
   output bls_pkg::coord_type    rsp_pixel_y,
   output logic                  rsp_valid_res,
   output logic                  rsp_last
);
   import bls_pkg::*;

   // line state
   coord_type  origin_x_ff,    origin_x_in;
   coord_type  origin_y_ff,    origin_y_in;
   coord_type  major_delta_ff, major_delta_in;
   coord_type  minor_delta_ff, minor_delta_in;
   coord_type  major_pos_ff,   major_pos_in;
   coord_type  minor_pos_ff,   minor_pos_in;
   err_type    error_ff,       error_in;
   octant_type octant_ff,      octant_in;
   logic       active_ff,      active_in;

   // output register
   logic       rsp_valid_ff,   rsp_valid_in;
   coord_type  pixel_x_ff,     pixel_x_in;
   coord_type  pixel_y_ff,     pixel_y_in;
   logic       valid_res_ff,   valid_res_in;
   logic       last_ff,        last_in;

   logic       req_fire;

   // take a new beat whenever the output register is free or draining
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   // next line state and response
   always_comb begin
      coord_type adx, ady;
      coord_type ox, oy;
      err_type   minor2, major2;
      logic      is_last;

      origin_x_in    = origin_x_ff;
      origin_y_in    = origin_y_ff;
      major_delta_in = major_delta_ff;
      minor_delta_in = minor_delta_ff;
      major_pos_in   = major_pos_ff;
      minor_pos_in   = minor_pos_ff;
      error_in       = error_ff;
      octant_in      = octant_ff;
      active_in      = active_ff;
      pixel_x_in     = pixel_x_ff;
      pixel_y_in     = pixel_y_ff;
      valid_res_in   = valid_res_ff;
      last_in        = last_ff;
      adx            = '0;
      ady            = '0;
      ox             = '0;
      oy             = '0;
      is_last        = 1'b0;
      minor2         = err_type'({minor_delta_ff, 1'b0});
      major2         = err_type'({major_delta_ff, 1'b0});

      if (req_fire) begin
         case (action_type'(req_action))
            ACT_START: begin
               // fold into the first octant
               octant_in = '0;
               if (req_end_x >= req_start_x) begin
                  adx = req_end_x - req_start_x;
               end else begin
                  adx = req_start_x - req_end_x;
                  octant_in.xneg = 1'b1;
               end
               if (req_end_y >= req_start_y) begin
                  ady = req_end_y - req_start_y;
               end else begin
                  ady = req_start_y - req_end_y;
                  octant_in.yneg = 1'b1;
               end
               if (ady > adx) begin
                  octant_in.swap = 1'b1;
                  major_delta_in = ady;
                  minor_delta_in = adx;
               end else begin
                  major_delta_in = adx;
                  minor_delta_in = ady;
               end
               origin_x_in  = req_start_x;
               origin_y_in  = req_start_y;
               major_pos_in = '0;
               minor_pos_in = '0;
               error_in     = err_type'({minor_delta_in, 1'b0})
                            - err_type'(major_delta_in);
               active_in    = (major_delta_in != '0);
               // first endpoint, zero offsets
               pixel_x_in   = req_start_x;
               pixel_y_in   = req_start_y;
               valid_res_in = 1'b1;
               last_in      = !active_in;
            end
            ACT_ADVANCE: begin
               if (!active_ff) begin
                  // no line: empty response
                  pixel_x_in   = '0;
                  pixel_y_in   = '0;
                  valid_res_in = 1'b0;
                  last_in      = 1'b0;
               end else begin
                  major_pos_in = major_pos_ff + 1'b1;
                  if (!error_ff[ERR_BITS-1]) begin
                     error_in     = error_ff + minor2 - major2;
                     minor_pos_in = minor_pos_ff + 1'b1;
                  end else begin
                     error_in     = error_ff + minor2;
                  end
                  is_last   = (major_pos_in >= major_delta_ff);
                  active_in = !is_last;
                  // unfold offsets back to screen space
                  if (octant_ff.swap) begin
                     ox = minor_pos_in;
                     oy = major_pos_in;
                  end else begin
                     ox = major_pos_in;
                     oy = minor_pos_in;
                  end
                  pixel_x_in   = octant_ff.xneg ? origin_x_ff - ox : origin_x_ff + ox;
                  pixel_y_in   = octant_ff.yneg ? origin_y_ff - oy : origin_y_ff + oy;
                  valid_res_in = 1'b1;
                  last_in      = is_last;
               end
            end
            default: begin
               valid_res_in = 1'b0;
            end
         endcase
      end
   end

   // output valid: set on a request beat, cleared when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      origin_x_ff    <= origin_x_in;
      origin_y_ff    <= origin_y_in;
      major_delta_ff <= major_delta_in;
      minor_delta_ff <= minor_delta_in;
      major_pos_ff   <= major_pos_in;
      minor_pos_ff   <= minor_pos_in;
      error_ff       <= error_in;
      octant_ff      <= octant_in;
      pixel_x_ff     <= pixel_x_in;
      pixel_y_ff     <= pixel_y_in;
      valid_res_ff   <= valid_res_in;
      last_ff        <= last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pixel_x   = pixel_x_ff;
   assign rsp_pixel_y   = pixel_y_ff;
   assign rsp_valid_res = valid_res_ff;
   assign rsp_last      = last_ff;

`ifndef SYNTHESIS
   // every accepted request shows up at the output next cycle
   a_fire_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid)
      else $error("request beat produced no response");

   // an active line has pixels left along the major axis
   a_active_pos: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (major_pos_ff < major_delta_ff))
      else $error("active line past its end");

   // minor axis never runs ahead of the major axis
   a_minor_le_major: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (minor_pos_ff <= major_pos_ff))
      else $error("minor offset ahead of major offset");

   // advance with no line gives an empty response
   a_idle_advance: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_action == ACT_ADVANCE && !active_ff)
      |=> (!rsp_valid_res && !rsp_last && rsp_pixel_x == '0 && rsp_pixel_y == '0))
      else $error("advance without line returned a pixel");

   // a last pixel ends the line
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (req_fire && last_in) |=> !active_ff)
      else $error("line still active after last pixel");
`endif

endmodule : bresenham_line_stepper_top

`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: regression bench for the all-octant Bresenham line stepper
// Drives start and advance beats with random gaps and response stalls, and
// tracks the folded line state on the side to predict every pixel beat.
// ---------------------------------------------------------------------------

module tb;

   import bls_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int TARGET_ITEMS   = 1650;
   localparam int MAX_REPORTS    = 10;

   typedef struct packed {
      coord_type x;
      coord_type y;
      logic      hit;
      logic      last;
   } pixel_beat_type;

   // line tracker: folds each start into the first octant, steps on advance,
   // and keeps the pixel beats the block still owes
   class pixel_checker;
      coord_type      org_x, org_y;
      coord_type      major_span, minor_span;
      coord_type      major_step, minor_step;
      err_type        decision;
      octant_type     fold;
      bit             line_open;
      pixel_beat_type expected_pixels[$];
      int             mismatches;

      function new();
         org_x      = '0;
         org_y      = '0;
         major_span = '0;
         minor_span = '0;
         major_step = '0;
         minor_step = '0;
         decision   = '0;
         fold       = '0;
         line_open  = 1'b0;
         mismatches = 0;
      endfunction

      // unfold the current offsets back to screen space
      function pixel_beat_type unfold(bit is_last);
         pixel_beat_type beat;
         coord_type      ox, oy;
         if (fold.swap) begin
            ox = minor_step;
            oy = major_step;
         end else begin
            ox = major_step;
            oy = minor_step;
         end
         beat.x    = fold.xneg ? org_x - ox : org_x + ox;
         beat.y    = fold.yneg ? org_y - oy : org_y + oy;
         beat.hit  = 1'b1;
         beat.last = is_last;
         return beat;
      endfunction

      function void accept_request(action_type act, coord_type sx, coord_type sy,
                                   coord_type ex, coord_type ey);
         coord_type adx, ady;
         bit        is_last;
         if (act == ACT_START) begin
            fold = '0;
            if (ex >= sx) begin
               adx = ex - sx;
            end else begin
               adx = sx - ex;
               fold.xneg = 1'b1;
            end
            if (ey >= sy) begin
               ady = ey - sy;
            end else begin
               ady = sy - ey;
               fold.yneg = 1'b1;
            end
            if (ady > adx) begin
               fold.swap  = 1'b1;
               major_span = ady;
               minor_span = adx;
            end else begin
               major_span = adx;
               minor_span = ady;
            end
            org_x      = sx;
            org_y      = sy;
            major_step = '0;
            minor_step = '0;
            decision   = err_type'(2 * int'(minor_span) - int'(major_span));
            line_open  = (major_span != '0);
            expected_pixels.push_back(unfold(!line_open));
         end else if (!line_open) begin
            // advance with nothing to draw
            expected_pixels.push_back('0);
         end else begin
            major_step = major_step + 1'b1;
            if (decision >= 0) begin
               decision = err_type'(int'(decision) + 2 * int'(minor_span)
                                    - 2 * int'(major_span));
               minor_step = minor_step + 1'b1;
            end else begin
               decision = err_type'(int'(decision) + 2 * int'(minor_span));
            end
            is_last = (major_step >= major_span);
            if (is_last)
               line_open = 1'b0;
            expected_pixels.push_back(unfold(is_last));
         end
      endfunction

      function void check_pixel(pixel_beat_type got);
         pixel_beat_type want;
         if (expected_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected pixel beat: x=%0d y=%0d valid=%0b last=%0b",
                        got.x, got.y, got.hit, got.last);
            return;
         end
         want = expected_pixels.pop_front();
         if (got.x !== want.x || got.y !== want.y ||
             got.hit !== want.hit || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display(
                  "pixel mismatch: exp x=%0d y=%0d v=%0b l=%0b, got x=%0d y=%0d v=%0b l=%0b",
                  want.x, want.y, want.hit, want.last,
                  got.x, got.y, got.hit, got.last);
         end
      endfunction

      function int outstanding();
         return expected_pixels.size();
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   action_type req_action = ACT_START;
   coord_type  req_start_x = '0;
   coord_type  req_start_y = '0;
   coord_type  req_end_x = '0;
   coord_type  req_end_y = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   coord_type  rsp_pixel_x;
   coord_type  rsp_pixel_y;
   logic       rsp_valid_res;
   logic       rsp_last;

   pixel_checker board = new();
   int  items_sent = 0;
   int  quiet_cycles = 0;
   bit  send_calm = 1'b0;
   bit  recv_calm = 1'b0;
   bit  drained_once = 1'b0;

   bresenham_line_stepper_top dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_action    (req_action),
      .req_start_x   (req_start_x),
      .req_start_y   (req_start_y),
      .req_end_x     (req_end_x),
      .req_end_y     (req_end_y),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_pixel_x   (rsp_pixel_x),
      .rsp_pixel_y   (rsp_pixel_y),
      .rsp_valid_res (rsp_valid_res),
      .rsp_last      (rsp_last)
   );

   always #5 clock = ~clock;

   // one request beat: optional gap, then hold until accepted
   task automatic send_beat(action_type act, coord_type sx, coord_type sy,
                            coord_type ex, coord_type ey);
      int gap;
      gap = send_calm ? 0 : $urandom_range(0, 10);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_action  <= act;
      req_start_x <= sx;
      req_start_y <= sy;
      req_end_x   <= ex;
      req_end_y   <= ey;
      do @(posedge clock); while (!req_ready);
      board.accept_request(act, sx, sy, ex, ey);
      items_sent++;
   endtask

   // start a line, then advance major span + extra times (clamped to cap)
   task automatic trace_line(coord_type sx, coord_type sy, coord_type ex,
                             coord_type ey, int extra, int cap);
      int adx, ady, n;
      adx = int'(ex) - int'(sx);
      ady = int'(ey) - int'(sy);
      if (adx < 0) adx = -adx;
      if (ady < 0) ady = -ady;
      n = ((adx > ady) ? adx : ady) + extra;
      if (n < 0) n = 0;
      if (n > cap) n = cap;
      send_beat(ACT_START, sx, sy, ex, ey);
      repeat (n)
         send_beat(ACT_ADVANCE, coord_type'($urandom()), coord_type'($urandom()),
                   coord_type'($urandom()), coord_type'($urandom()));
   endtask

   // endpoint a few pixels away from base, kept on screen
   function automatic coord_type near_coord(coord_type base);
      int offs, pos;
      offs = int'($urandom_range(0, 24)) - 12;
      pos  = int'(base) + offs;
      if (pos < 0 || pos > 4095)
         pos = int'(base) - offs;
      return coord_type'(pos);
   endfunction

   // response side: random stalls per beat, with calm stretches
   initial begin
      int stall;
      wait (!reset);
      forever begin
         if ($urandom_range(0, 19) == 0)
            recv_calm = ~recv_calm;
         stall = recv_calm ? 0 : $urandom_range(0, 10);
         @(negedge clock);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_pixel('{rsp_pixel_x, rsp_pixel_y, rsp_valid_res, rsp_last});
   end

   // watchdog: cycles with no beat on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      coord_type sx, sy;
      int        pick, extra;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: advance with no line, zero-length line, extremes, octants
      send_beat(ACT_ADVANCE, '1, '1, '1, '1);
      trace_line(12'd5, 12'd5, 12'd5, 12'd5, 1, 10);
      trace_line(12'd0, 12'd0, 12'd4095, 12'd4095, 0, 3);
      // restart while the diagonal is still open
      trace_line(12'd4095, 12'd4095, 12'd0, 12'd0, 0, 2);
      trace_line(12'd4095, 12'd0, 12'd4092, 12'd2, 1, 10);
      trace_line(12'd0, 12'd4095, 12'd1, 12'd4091, 0, 10);
      trace_line(12'd10, 12'd20, 12'd12, 12'd20, 0, 10);
      trace_line(12'd30, 12'd40, 12'd30, 12'd37, 0, 10);

      // random: mostly complete short lines, some long, some noise
      while (items_sent < TARGET_ITEMS) begin
         if ($urandom_range(0, 14) == 0)
            send_calm = ~send_calm;
         if (!drained_once && items_sent >= TARGET_ITEMS / 2) begin
            drained_once = 1'b1;
            // hold off new beats until every pixel is back
            @(negedge clock);
            req_valid <= 1'b0;
            while (board.outstanding() != 0) @(posedge clock);
         end
         pick = $urandom_range(0, 99);
         sx = coord_type'($urandom());
         sy = coord_type'($urandom());
         if (pick < 80) begin
            extra = $urandom_range(0, 9);
            if (extra <= 6)
               extra = 0;
            else if (extra <= 8)
               extra = $urandom_range(1, 2);
            else
               extra = -int'($urandom_range(1, 6));
            trace_line(sx, sy, near_coord(sx), near_coord(sy), extra, 64);
         end else if (pick < 88) begin
            trace_line(sx, sy, coord_type'($urandom()), coord_type'($urandom()), 0,
                       $urandom_range(20, 300));
         end else if (pick < 94) begin
            send_beat(ACT_ADVANCE, coord_type'($urandom()), coord_type'($urandom()),
                      coord_type'($urandom()), coord_type'($urandom()));
         end else begin
            send_beat(ACT_START, sx, sy, coord_type'($urandom()),
                      coord_type'($urandom()));
         end
      end

      // drain and let the pipeline settle
      @(negedge clock);
      req_valid <= 1'b0;
      while (board.outstanding() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (board.mismatches == 0 && board.outstanding() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
